@@ rtl/ils_pkg.sv @@
// ----------------------------------------------------------------------------
// ils_pkg
// Types, character constants and decode helpers for the integer literal
// scanner.
// ----------------------------------------------------------------------------
package ils_pkg;

    typedef enum logic [1:0] {
        PH_START  = 2'd0,
        PH_MINUS  = 2'd1,
        PH_ZERO   = 2'd2,
        PH_DIGITS = 2'd3
    } phase_t;

    typedef enum logic [1:0] {
        ERR_NONE     = 2'd0,
        ERR_OVERFLOW = 2'd1,
        ERR_BADCHAR  = 2'd2
    } err_t;

    typedef struct packed {
        logic       ok;
        logic [3:0] val;
    } hex_t;

    localparam logic [7:0] CHAR_MINUS = 8'h2D;
    localparam logic [7:0] CHAR_ZERO  = 8'h30;
    localparam logic [7:0] CHAR_NINE  = 8'h39;

    localparam logic [4:0] RADIX_NONE = 5'd0;
    localparam logic [4:0] RADIX_BIN  = 5'd2;
    localparam logic [4:0] RADIX_OCT  = 5'd8;
    localparam logic [4:0] RADIX_DEC  = 5'd10;
    localparam logic [4:0] RADIX_HEX  = 5'd16;

    function automatic hex_t hex_value(input logic [7:0] ch);
        hex_t h;
        h.ok  = 1'b1;
        h.val = 4'd0;
        if (ch inside {[CHAR_ZERO:CHAR_NINE]}) begin
            h.val = 4'(ch - CHAR_ZERO);
        end else if (ch inside {["a":"f"]}) begin
            h.val = 4'(ch - 8'h57);
        end else if (ch inside {["A":"F"]}) begin
            h.val = 4'(ch - 8'h37);
        end else begin
            h.ok = 1'b0;
        end
        return h;
    endfunction

    function automatic logic [4:0] prefix_radix(input logic [7:0] ch);
        logic [4:0] r;
        case (ch)
            "b", "B": r = RADIX_BIN;
            "o", "O": r = RADIX_OCT;
            "d", "D": r = RADIX_DEC;
            "x", "X": r = RADIX_HEX;
            default:  r = RADIX_NONE;
        endcase
        return r;
    endfunction

endpackage

@@ rtl/ils_core.sv @@
// ----------------------------------------------------------------------------
// ils_core
// Literal state (phase, radix, sign, magnitude, fault) and the per-character
// update, with the result formed from the updated state.
// ----------------------------------------------------------------------------
module ils_core #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic                   aclk,
    input  logic                   aresetn,
    input  logic                   step_en,
    input  logic [7:0]             char_in,
    input  logic                   last_char,
    output logic [VALUE_WIDTH-1:0] res_value,
    output ils_pkg::err_t          res_error
);

    localparam int ACC_W  = VALUE_WIDTH - 1;
    localparam int PROD_W = ACC_W + 5;

    ils_pkg::phase_t phase_reg, phase_next;
    logic [4:0]      radix_reg, radix_next;
    logic            negative_reg, negative_next;
    logic [ACC_W-1:0] acc_reg, acc_next;
    ils_pkg::err_t   fault_reg, fault_next;

    ils_pkg::hex_t   digit;
    logic [4:0]      pr;
    logic            take;
    logic [PROD_W-1:0] sum;
    logic [PROD_W-1:0] limit;
    logic [VALUE_WIDTH-1:0] mag;

    always_comb begin
        digit = ils_pkg::hex_value(char_in);
        pr    = ils_pkg::prefix_radix(char_in);
        limit = PROD_W'({ACC_W{1'b1}});
        // acc*radix + d; radix is at most 16, so the product stays narrow
        sum   = PROD_W'(acc_reg) * PROD_W'(radix_reg) + PROD_W'(digit.val);
    end

    always_comb begin
        phase_next    = phase_reg;
        radix_next    = radix_reg;
        negative_next = negative_reg;
        acc_next      = acc_reg;
        fault_next    = fault_reg;
        take          = 1'b0;
        if (fault_reg == ils_pkg::ERR_NONE) begin
            case (phase_reg)
                ils_pkg::PH_START: begin
                    if (char_in == ils_pkg::CHAR_MINUS) begin
                        negative_next = 1'b1;
                        phase_next    = ils_pkg::PH_MINUS;
                    end else if (char_in == ils_pkg::CHAR_ZERO) begin
                        phase_next = ils_pkg::PH_ZERO;
                    end else begin
                        phase_next = ils_pkg::PH_DIGITS;
                        take       = 1'b1;
                    end
                end
                ils_pkg::PH_MINUS: begin
                    phase_next = (char_in == ils_pkg::CHAR_ZERO) ? ils_pkg::PH_ZERO
                                                                 : ils_pkg::PH_DIGITS;
                    take       = (char_in != ils_pkg::CHAR_ZERO);
                end
                ils_pkg::PH_ZERO: begin
                    phase_next = ils_pkg::PH_DIGITS;
                    if (pr != ils_pkg::RADIX_NONE) begin
                        radix_next = pr;
                    end else begin
                        take = 1'b1;
                    end
                end
                default: begin
                    take = 1'b1;
                end
            endcase
        end
        if (take) begin
            if (!digit.ok) begin
                fault_next = ils_pkg::ERR_BADCHAR;
            end else if (sum >= limit) begin
                fault_next = ils_pkg::ERR_OVERFLOW;
            end else begin
                acc_next = sum[ACC_W-1:0];
            end
        end
    end

    always_comb begin
        mag       = {1'b0, acc_next};
        res_error = fault_next;
        if (fault_next != ils_pkg::ERR_NONE) begin
            res_value = '0;
        end else if (negative_next) begin
            res_value = VALUE_WIDTH'(0) - mag;
        end else begin
            res_value = mag;
        end
    end

    // the last character returns the scanner to its start state
    always_ff @(posedge aclk) begin
        if (!aresetn || (step_en && last_char)) begin
            phase_reg    <= ils_pkg::PH_START;
            radix_reg    <= ils_pkg::RADIX_DEC;
            negative_reg <= 1'b0;
            acc_reg      <= '0;
            fault_reg    <= ils_pkg::ERR_NONE;
        end else if (step_en) begin
            phase_reg    <= phase_next;
            radix_reg    <= radix_next;
            negative_reg <= negative_next;
            acc_reg      <= acc_next;
            fault_reg    <= fault_next;
        end
    end

    a_acc_below_limit: assert property (@(posedge aclk) disable iff (!aresetn)
        acc_reg != {ACC_W{1'b1}})
        else $error("magnitude reached the overflow limit");

endmodule

@@ rtl/integer_literal_scanner.sv @@
// The result of a literal's last character reaches m_axis through the input
// register, then the result register.
// Throughput: one character per cycle while no last character is held back,
// set by the combinational multiply-add on the magnitude register; a result
// stalled on m_axis holds back a last character and every one behind it.
// Reset: synchronous, active low; clears the valid flags of both register stages and the state.
// ----------------------------------------------------------------------------
// integer_literal_scanner
// Turns a stream of ASCII characters of an integer literal into a signed
// binary value with an error code, one result per literal.
// ----------------------------------------------------------------------------
module integer_literal_scanner #(
    parameter int VALUE_WIDTH = 32
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [7:0]  s_axis_tdata,   // [7:0] char_in
    input  logic        s_axis_tlast,   // last_char
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [VALUE_WIDTH-1:0] value, [VALUE_WIDTH+1:VALUE_WIDTH] error_code, zero fill
    output logic [((VALUE_WIDTH+2+7)/8)*8-1:0] m_axis_tdata
);

    localparam int TDATA_W = ((VALUE_WIDTH + 2 + 7) / 8) * 8;

    logic       in_valid_reg, in_valid_next;
    logic [7:0] in_char_reg;
    logic       in_last_reg;

    logic                   out_valid_reg, out_valid_next;
    logic [VALUE_WIDTH-1:0] out_value_reg;
    ils_pkg::err_t          out_error_reg;

    logic                   advance;
    logic                   s_accept;
    logic [VALUE_WIDTH-1:0] res_value;
    ils_pkg::err_t          res_error;

    // an item leaves the input register unless it is a last character
    // blocked by an untaken result
    assign advance       = in_valid_reg && (!in_last_reg || !out_valid_reg || m_axis_tready);
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_accept      = s_axis_tvalid && s_axis_tready;

    ils_core #(
        .VALUE_WIDTH (VALUE_WIDTH)
    ) u_core (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step_en   (advance),
        .char_in   (in_char_reg),
        .last_char (in_last_reg),
        .res_value (res_value),
        .res_error (res_error)
    );

    always_comb begin
        in_valid_next = s_accept ? 1'b1 : (advance ? 1'b0 : in_valid_reg);
        if (advance && in_last_reg) begin
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end else begin
            out_valid_next = out_valid_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            in_char_reg <= s_axis_tdata;
            in_last_reg <= s_axis_tlast;
        end
        if (advance && in_last_reg) begin
            out_value_reg <= res_value;
            out_error_reg <= res_error;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = TDATA_W'({out_error_reg, out_value_reg});

    a_error_zero_value: assert property (@(posedge aclk) disable iff (!aresetn)
        (out_valid_reg && out_error_reg != ils_pkg::ERR_NONE) |-> (out_value_reg == '0))
        else $error("error result with non-zero value");

    a_inner_char_flows: assert property (@(posedge aclk) disable iff (!aresetn)
        (in_valid_reg && !in_last_reg) |-> advance)
        else $error("inner character held in input register");

    a_result_from_last: assert property (@(posedge aclk) disable iff (!aresetn)
        (!out_valid_reg && $past(!out_valid_reg) && out_valid_next) |-> in_last_reg)
        else $error("result raised without a last character");

    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> (!in_valid_reg && !out_valid_reg))
        else $error("stages not cleared by reset");

endmodule
